// File: rtl/otc_pkg.sv
// Shared types, codes and constants of the oscillator trim calibrator.
package otc_pkg;

	// Default sizes handed to the top level
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int TRIM_MAX_DEF    = 127;

	// Fixed field widths
	localparam int CAPTURE_W  = 16;
	localparam int TRIM_W     = 7;
	localparam int INTERVAL_W = 16;
	localparam int TARGET_W   = 16;
	localparam int ROUNDS_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Window margin is target/200, done as ((target >> 3) * 5243) >> 17,
	// exact for every 16-bit target
	localparam int MARGIN_DIV   = 200;
	localparam int MARGIN_PRE   = 3;
	localparam int MARGIN_MUL   = 5243;
	localparam int MARGIN_SHIFT = 17;
	localparam int MARGIN_W     = 9;
	localparam int HI_W         = TARGET_W + 1;

	// Register reset values
	localparam int TARGET_RESET = 1000;
	localparam int ROUNDS_RESET = 65;
	localparam int HI_RESET     = TARGET_RESET + TARGET_RESET / MARGIN_DIV;
	localparam int LO_RESET     = TARGET_RESET - TARGET_RESET / MARGIN_DIV;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS   = 2'd1;

	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_EDGE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ARMED   = 3'd1,
		ST_WAITING = 3'd2,
		ST_DOWN    = 3'd3,
		ST_UP      = 3'd4,
		ST_DONE    = 3'd5,
		ST_SPENT   = 3'd6
	} status_t;

	typedef struct packed {
		op_t                  operation;
		logic [CAPTURE_W-1:0] capture;
	} item_t;

	typedef struct packed {
		logic [TRIM_W-1:0]     trim;
		logic [INTERVAL_W-1:0] interval;
		status_t               status;
	} result_t;

	// Acceptance window and budget, as held by the register block
	typedef struct packed {
		logic [HI_W-1:0]     hi;
		logic [TARGET_W-1:0] lo;
		logic [ROUNDS_W-1:0] max_rounds;
	} cfg_t;

endpackage

// File: rtl/otc_cfg.sv
// Configuration registers with the acceptance window worked out on write.
module otc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [otc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [otc_pkg::CFG_DATA_W-1:0] cfg_data,
	output otc_pkg::cfg_t                   cfg
);
	import otc_pkg::*;

	localparam int PROD_W = TARGET_W + 13;

	logic [PROD_W-1:0]   margin_prod;
	logic [MARGIN_W-1:0] margin;
	logic [TARGET_W-1:0] target_wr;
	logic [HI_W-1:0]     hi_q;
	logic [TARGET_W-1:0] lo_q;
	logic [ROUNDS_W-1:0] max_rounds_q;

	assign cfg_ready = 1'b1;

	// Margin of the written target, floor(target / 200)
	assign target_wr   = TARGET_W'(cfg_data);
	assign margin_prod = PROD_W'(target_wr >> MARGIN_PRE) * PROD_W'(MARGIN_MUL);
	assign margin      = margin_prod[MARGIN_SHIFT +: MARGIN_W];

	// Hold window bounds and round budget
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q         <= HI_W'(HI_RESET);
			lo_q         <= TARGET_W'(LO_RESET);
			max_rounds_q <= ROUNDS_W'(ROUNDS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_TICKS: begin
					hi_q <= HI_W'(target_wr) + HI_W'(margin);
					lo_q <= target_wr - TARGET_W'(margin);
				end
				REG_MAX_ROUNDS: begin
					max_rounds_q <= cfg_data[ROUNDS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.hi         = hi_q;
	assign cfg.lo         = lo_q;
	assign cfg.max_rounds = max_rounds_q;

endmodule

// File: rtl/otc_step.sv
// Calibration state and the per-item step: pair capture, interval check, trim step.
module otc_step #(
	parameter int COUNT_WIDTH = otc_pkg::COUNT_WIDTH_DEF,
	parameter int TRIM_MAX    = otc_pkg::TRIM_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  otc_pkg::item_t   item,
	input  otc_pkg::cfg_t    cfg,
	output otc_pkg::result_t result
);
	import otc_pkg::*;

	localparam int TW    = $clog2(TRIM_MAX + 1);
	localparam int CMP_W = (COUNT_WIDTH > HI_W) ? COUNT_WIDTH : HI_W;
	localparam logic [TW-1:0] TRIM_TOP    = TW'(TRIM_MAX);
	localparam logic [TW-1:0] TRIM_CENTRE = TW'(TRIM_MAX / 2);

	logic [TW-1:0]          trim_q, trim_n;
	logic [COUNT_WIDTH-1:0] start_q, start_n;
	logic                   phase_q, phase_n;
	logic [ROUNDS_W-1:0]    rounds_q, rounds_n, rounds_dec;
	logic                   running_q, running_n;

	logic [COUNT_WIDTH-1:0] cap_cw;
	logic [COUNT_WIDTH-1:0] diff;
	logic [CMP_W-1:0]       diff_x;
	logic                   too_long, too_short;
	logic [INTERVAL_W-1:0]  interval;
	status_t                status;

	// Modular interval of the pair
	assign cap_cw     = COUNT_WIDTH'(item.capture);
	assign diff       = cap_cw - start_q;
	assign diff_x     = CMP_W'(diff);
	assign too_long   = diff_x > CMP_W'(cfg.hi);
	assign too_short  = diff_x < CMP_W'(cfg.lo);
	assign rounds_dec = (rounds_q != '0) ? rounds_q - 1'b1 : '0;

	// Work out next state and the result for the item in hand
	always_comb begin
		trim_n    = trim_q;
		start_n   = start_q;
		phase_n   = phase_q;
		rounds_n  = rounds_q;
		running_n = running_q;
		interval  = '0;
		status    = ST_IDLE;
		case (item.operation)
			OP_START: begin
				trim_n   = TRIM_CENTRE;
				phase_n  = 1'b0;
				rounds_n = cfg.max_rounds;
				if (cfg.max_rounds == '0) begin
					running_n = 1'b0;
					status    = ST_SPENT;
				end else begin
					running_n = 1'b1;
					status    = ST_ARMED;
				end
			end
			OP_EDGE: begin
				if (!running_q) begin
					status = ST_IDLE;
				end else if (!phase_q) begin
					start_n = cap_cw;
					phase_n = 1'b1;
					status  = ST_WAITING;
				end else begin
					phase_n  = 1'b0;
					rounds_n = rounds_dec;
					interval = INTERVAL_W'(diff);
					if (too_long && trim_q != '0) begin
						trim_n = trim_q - 1'b1;
						status = ST_DOWN;
					end else if (too_short && trim_q < TRIM_TOP) begin
						trim_n = trim_q + 1'b1;
						status = ST_UP;
					end else begin
						running_n = 1'b0;
						status    = ST_DONE;
					end
					// Last round spent on a step ends the run
					if ((status == ST_DOWN || status == ST_UP) && rounds_dec == '0) begin
						running_n = 1'b0;
						status    = ST_SPENT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result.trim     = TRIM_W'(trim_n);
	assign result.interval = interval;
	assign result.status   = status;

	// Advance control state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q    <= TRIM_CENTRE;
			phase_q   <= 1'b0;
			rounds_q  <= '0;
			running_q <= 1'b0;
		end else if (fire) begin
			trim_q    <= trim_n;
			phase_q   <= phase_n;
			rounds_q  <= rounds_n;
			running_q <= running_n;
		end
	end

	// Hold the first capture of a pair
	always_ff @(posedge clk) begin
		if (fire) begin
			start_q <= start_n;
		end
	end

	a_trim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		trim_q <= TRIM_TOP)
		else $error("trim left its range");

	a_idle_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> !phase_q)
		else $error("pair half open while idle");

	a_stop_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> $past(fire))
		else $error("calibration stopped without an item");

	a_start_centres: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_START |=> trim_q == TRIM_CENTRE)
		else $error("start did not centre the trim");

endmodule

// File: rtl/oscillator_trim_calibrator_core.sv
// Top level of the oscillator trim calibrator: input register, step logic, result register.
//
//  channel | signals                          | payload
//  --------+----------------------------------+-----------------------------
//  item    | item_valid, item_stall (out)     | item: operation, capture
//  result  | result_valid, result_stall (in)  | result: trim, interval, status
//  cfg     | cfg_valid, cfg_ready (out)       | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; each taken item passes the input
// register, then the step logic and the result register, before its result is offered.
// Reset puts the trim at its centre, idle, with the register defaults; no clearing pass.
// A stalled result holds; the input register fills behind it, then item_stall rises.
// cfg_ready is always high; a target write updates the window at the same edge.
module oscillator_trim_calibrator_core #(
	parameter int COUNT_WIDTH = otc_pkg::COUNT_WIDTH_DEF,
	parameter int TRIM_MAX    = otc_pkg::TRIM_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  otc_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output otc_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [otc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [otc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import otc_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t result_n;
	cfg_t    cfg;
	logic    adv;
	logic    fire;
	logic    take;

	// Result register frees up when empty or taken
	assign adv        = !result_valid_q || !result_stall;
	assign fire       = item_valid_s1 && adv;
	assign item_stall = item_valid_s1 && !adv;
	assign take       = item_valid && !item_stall;

	otc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	otc_step #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TRIM_MAX    (TRIM_MAX)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_n)
	);

	// Track occupancy of input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				item_valid_s1 <= item_valid;
			end
			if (adv) begin
				result_valid_q <= item_valid_s1;
			end
		end
	end

	// Load payloads
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
